/* rtl/core/lstm_cell_step_core_defines.svh */
// Assertion macros for the LSTM step core.
// Included by lstm_cell_step_core, the module that carries concurrent checks.
`ifndef LSTM_CELL_STEP_CORE_DEFINES_SVH
`define LSTM_CELL_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define LSC_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/lsc_pkg.sv */
// Shared types, constants and a rounding function for the LSTM step core.
// No dependencies.
package lsc_pkg;
  localparam int NumInputsDef = 4;
  localparam int NumUnitsDef  = 8;
  localparam int NumGates     = 4;
  localparam int MaxInput     = 4;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_STEP   = 2'd2;

  localparam logic [1:0] GATE_IN   = 2'd0;
  localparam logic [1:0] GATE_FGT  = 2'd1;
  localparam logic [1:0] GATE_CAND = 2'd2;
  localparam logic [1:0] GATE_OUT  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_MAC, ST_ACT, ST_CELL, ST_TANH, ST_HID, ST_EMIT
  } state_t;

  // Divider request bundle from the sequencer to the divider.
  // The denominator reaches 2^17 when exp(-a) is one.
  typedef struct packed {
    logic        start;
    logic [40:0] num;
    logic [17:0] den;
  } div_req_t;

  // Round to Q4.12 (add half, floor) then saturate.
  function automatic logic signed [15:0] to_q12(input logic signed [39:0] v);
    logic signed [39:0] q;
    q = (v + 40'sd2048) >>> 12;
    if (q > 40'sd32767) to_q12 = 16'sh7fff;
    else if (q < -40'sd32768) to_q12 = 16'sh8000;
    else to_q12 = q[15:0];
  endfunction
endpackage

/* rtl/core/lsc_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module lsc_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/lsc_exp.sv */
// exp(-a) in Q16 for a Q4.12 argument; one fraction bit per cycle.
// Depends on lsc_pkg.
module lsc_exp
  import lsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] arg,
  output logic        done,
  output logic [16:0] result
);
  localparam logic [15:0] STEPS [8] = '{16'd46341, 16'd55109, 16'd60097, 16'd62757,
                                        16'd64132, 16'd64830, 16'd65182, 16'd65359};
  logic [16:0] e_r, e_nxt;
  logic [19:0] y_r, y_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        busy_r, busy_nxt;
  logic [36:0] ya;
  logic [32:0] prod;
  logic [19:0] n;

  assign ya   = arg * 20'd23637;
  assign prod = e_r * STEPS[k_r[2:0]] + 33'd32768;
  assign n    = y_r >> 12;

  // Eight fraction steps, then done is raised with the result held
  always_comb begin
    e_nxt = e_r; y_nxt = y_r; k_nxt = k_r; busy_nxt = busy_r;
    if (start) begin
      e_nxt = 17'd65536; y_nxt = ya[33:14]; k_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (k_r == 4'd8) busy_nxt = 1'b0;
      else begin
        if (y_r[11 - k_r[2:0]]) e_nxt = prod[32:16];
        k_nxt = k_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
    e_r <= e_nxt; y_r <= y_nxt; k_r <= k_nxt;
  end

  assign done   = busy_r && (k_r == 4'd8);
  assign result = (n >= 20'd31) ? 17'd0 : (e_r >> n[4:0]);
endmodule

/* rtl/core/lsc_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on lsc_pkg.
module lsc_div
  import lsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [40:0] quot
);
  logic [40:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [17:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] sh;

  // Remainder stays below the denominator, at most 2^17
  assign sh = {rem_r, q_r[40]};

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; den_nxt = req.den; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= den_r) begin
        rem_nxt = 17'(sh - den_r); q_nxt = {q_r[39:0], 1'b1};
      end else begin
        rem_nxt = sh[16:0]; q_nxt = {q_r[39:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd40) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

/* rtl/core/lsc_lane.sv */
// One input lane: weight memory slice and multiplier for one row element.
// Depends on lsc_pkg, lsc_ram.
module lsc_lane
  import lsc_pkg::*;
#(
  parameter int Depth = NumGates * NumUnitsDef
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [15:0]              wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  input  logic signed [15:0]       x,
  output logic signed [31:0]       prod_r
);
  logic [15:0] w;
  lsc_ram #(.Width(16), .Depth(Depth)) u_wram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata(w)
  );
  always_ff @(posedge clk) prod_r <= x * $signed(w);
endmodule

/* rtl/core/lstm_cell_step_core.sv */
// LSTM step core, signed Q4.12. Loads can run back to back. A step holds in_stall
// until its last unit is emitted, output stalls included. Per gate: read, merge,
// activation (exp unit, then bit-serial divider); the activations set the rate.
// Synchronous active-low reset clears control and the cell store.
`include "lstm_cell_step_core_defines.svh"
module lstm_cell_step_core
  import lsc_pkg::*;
#(
  parameter int NUM_INPUTS = NumInputsDef,
  parameter int NUM_UNITS  = NumUnitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [1:0]         in_gate_select,
  input  logic [1:0]         in_row_index,
  input  logic [3:0]         in_unit_index,
  input  logic signed [15:0] in_param_value,
  input  logic signed [15:0] in_x0,
  input  logic signed [15:0] in_x1,
  input  logic signed [15:0] in_x2,
  input  logic signed [15:0] in_x3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_out_unit,
  output logic signed [15:0] out_hidden_value,
  output logic signed [15:0] out_cell_value,
  output logic               out_last
);
  localparam int UW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int GD = NumGates * (1 << UW);
  localparam int GW = $clog2(GD);
  localparam logic [UW-1:0] LAST_U = UW'(NUM_UNITS - 1);

  state_t state_r, state_nxt;
  logic acc_in, acc_out;
  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  // Load decode
  logic w_we, b_we;
  logic [GW-1:0] ld_addr;
  assign ld_addr = GW'({in_gate_select, UW'(in_unit_index)}) ;
  assign w_we = acc_in && in_req_type == REQ_WEIGHT
                && {1'b0, in_unit_index} < 5'(NUM_UNITS)
                && {1'b0, in_row_index} < 3'(NUM_INPUTS);
  assign b_we = acc_in && in_req_type == REQ_BIAS
                && {1'b0, in_unit_index} < 5'(NUM_UNITS);

  // Latched row
  logic signed [15:0] x_r [MaxInput];
  always_ff @(posedge clk)
    if (acc_in && in_req_type == REQ_STEP) begin
      x_r[0] <= in_x0; x_r[1] <= in_x1; x_r[2] <= in_x2; x_r[3] <= in_x3;
    end

  logic [UW-1:0] unit_r, unit_nxt;
  logic [1:0] gate_r, gate_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [GW-1:0] raddr;
  assign raddr = GW'({gate_r, unit_r});

  // Lanes
  logic signed [31:0] prod [MaxInput];
  for (genvar l = 0; l < MaxInput; l++) begin : g_lane
    if (l < NUM_INPUTS) begin : g_on
      lsc_lane #(.Depth(GD)) u_lane (
        .clk, .we(w_we && in_row_index == 2'(l)), .waddr(ld_addr),
        .wdata(in_param_value), .raddr, .x(x_r[l]), .prod_r(prod[l])
      );
    end else begin : g_off
      assign prod[l] = '0;
    end
  end

  logic [15:0] bias;
  lsc_ram #(.Width(16), .Depth(GD)) u_bram (
    .clk, .we(b_we), .waddr(ld_addr), .wdata(in_param_value), .raddr, .rdata(bias)
  );

  // Merge stage: sum lanes plus shifted bias
  logic signed [39:0] sum;
  always_comb begin
    sum = 40'($signed(bias)) <<< 12;
    for (int l = 0; l < MaxInput; l++) sum = sum + 40'(prod[l]);
  end

  // Shared exp + divider
  logic ex_start, ex_done;
  logic [16:0] ex_arg, ex_res;
  lsc_exp u_exp (.clk, .rst_n, .start(ex_start), .arg(ex_arg), .done(ex_done), .result(ex_res));
  div_req_t dreq;
  logic dv_done;
  logic [40:0] dv_q;
  lsc_div u_div (.clk, .rst_n, .req(dreq), .done(dv_done), .quot(dv_q));

  logic signed [15:0] arg_r, arg_nxt;
  logic signed [15:0] act_r [NumGates];
  logic signed [15:0] act_nxt [NumGates];
  logic signed [15:0] c_r, c_nxt, tc_r, tc_nxt;
  logic signed [15:0] cell_r [NUM_UNITS];
  logic cell_we;
  logic is_tanh;
  logic [16:0] a_abs;
  logic [17:0] d_r, d_nxt;
  logic [16:0] e_r, e_nxt;
  logic signed [15:0] fn;
  logic signed [31:0] p0_r, p1_r, p0_nxt, p1_nxt;
  logic ov_r, ov_nxt;
  logic [3:0] ou_r, ou_nxt;
  logic signed [15:0] oh_r, oh_nxt, oc_r, oc_nxt;
  logic ol_r, ol_nxt;

  assign is_tanh = (state_r == ST_TANH) || (gate_r == GATE_CAND && state_r == ST_ACT);
  assign a_abs = arg_r[15] ? 17'(-$signed({arg_r[15], arg_r})) : {1'b0, arg_r};
  assign ex_arg = is_tanh ? {a_abs[15:0], 1'b0} : a_abs;

  // Final function value from quotient and sign
  always_comb begin
    logic signed [15:0] m;
    m = 16'(dv_q);
    if (is_tanh) fn = arg_r[15] ? -m : m;
    else fn = arg_r[15] ? 16'sd4096 - m : m;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = ov_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r; unit_nxt = unit_r; gate_nxt = gate_r; ph_nxt = ph_r;
    arg_nxt = arg_r; c_nxt = c_r; tc_nxt = tc_r; d_nxt = d_r; e_nxt = e_r;
    p0_nxt = p0_r; p1_nxt = p1_r; cell_we = 1'b0;
    for (int g = 0; g < NumGates; g++) act_nxt[g] = act_r[g];
    ov_nxt = ov_r && !acc_out; ou_nxt = ou_r; oh_nxt = oh_r; oc_nxt = oc_r; ol_nxt = ol_r;
    ex_start = 1'b0; dreq = '0;
    unique case (state_r)
      ST_IDLE: if (acc_in && in_req_type == REQ_STEP) begin
        state_nxt = ST_RD; unit_nxt = '0; gate_nxt = GATE_IN; ph_nxt = '0;
      end
      ST_RD: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd1) begin ph_nxt = '0; state_nxt = ST_MAC; end
      end
      ST_MAC: begin
        arg_nxt = to_q12(sum); state_nxt = ST_ACT; ph_nxt = '0;
      end
      ST_ACT, ST_TANH: begin
        if (ph_r == 2'd0) begin ex_start = 1'b1; ph_nxt = 2'd1; end
        else if (ph_r == 2'd1 && ex_done) begin
          e_nxt = ex_res; d_nxt = 18'd65536 + {1'b0, ex_res}; ph_nxt = 2'd2;
        end else if (ph_r == 2'd2) begin
          dreq.start = 1'b1; dreq.den = d_r;
          dreq.num = is_tanh ? 41'((34'(17'd65536 - e_r) << 12) + 34'(d_r >> 1))
                             : 41'(29'h1000_0000 + 29'(d_r >> 1));
          ph_nxt = 2'd3;
        end else if (ph_r == 2'd3 && dv_done) begin
          ph_nxt = '0;
          if (state_r == ST_TANH) begin
            tc_nxt = fn; state_nxt = ST_HID;
          end else begin
            act_nxt[gate_r] = fn;
            if (gate_r == GATE_OUT) state_nxt = ST_CELL;
            else begin gate_nxt = gate_r + 2'd1; state_nxt = ST_RD; end
          end
        end
      end
      ST_CELL: begin
        if (ph_r == 2'd0) begin
          p0_nxt = act_r[GATE_FGT] * cell_r[unit_r];
          p1_nxt = act_r[GATE_IN] * act_r[GATE_CAND];
          ph_nxt = 2'd1;
        end else begin
          c_nxt = to_q12(40'(p0_r) + 40'(p1_r)); arg_nxt = c_nxt;
          ph_nxt = '0; state_nxt = ST_TANH;
        end
      end
      ST_HID: begin
        if (ph_r == 2'd0) begin p0_nxt = act_r[GATE_OUT] * tc_r; ph_nxt = 2'd1; end
        else begin
          oh_nxt = to_q12(40'(p0_r)); oc_nxt = c_r; ou_nxt = 4'(unit_r);
          ol_nxt = (unit_r == LAST_U); ov_nxt = 1'b1; cell_we = 1'b1;
          ph_nxt = '0; state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: if (!ov_r) begin
        if (unit_r == LAST_U) state_nxt = ST_IDLE;
        else begin
          unit_nxt = unit_r + UW'(1); gate_nxt = GATE_IN; state_nxt = ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ov_r <= 1'b0; ph_r <= '0;
      for (int u = 0; u < NUM_UNITS; u++) cell_r[u] <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; ph_r <= ph_nxt;
      if (cell_we) cell_r[unit_r] <= c_r;
    end
    unit_r <= unit_nxt; gate_r <= gate_nxt; arg_r <= arg_nxt; c_r <= c_nxt; tc_r <= tc_nxt;
    d_r <= d_nxt; e_r <= e_nxt; p0_r <= p0_nxt; p1_r <= p1_nxt;
    for (int g = 0; g < NumGates; g++) act_r[g] <= act_nxt[g];
    ou_r <= ou_nxt; oh_r <= oh_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt;
  end

  assign out_out_unit = ou_r;
  assign out_hidden_value = oh_r;
  assign out_cell_value = oc_r;
  assign out_last = ol_r;

  `LSC_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != ST_IDLE) |-> !acc_in, "busy accept")
  `LSC_ASSERT(a_out_only_step, clk, rst_n, $rose(ov_r) |-> $past(state_r == ST_HID), "stray out")
  `LSC_ASSERT(a_last_ends, clk, rst_n, (acc_out && ol_r) |=> (state_r == ST_EMIT), "bad end")
endmodule
